// ===== sv/stt_pkg.sv =====
`timescale 1ns / 1ps

package stt_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 24;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int SLOTS       = 3;

    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_STRING  = 3'd1;
    localparam logic [2:0] KIND_LBEGIN  = 3'd2;
    localparam logic [2:0] KIND_LEND    = 3'd3;
    localparam logic [2:0] KIND_EOT     = 3'd4;
    localparam logic [2:0] KIND_UNTERM  = 3'd5;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;
    localparam logic [1:0] MODE_LITERAL = 2'd3;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             token_kind;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   start_line;
        logic [LINE_BITS-1:0]   start_column;
        logic                   run_end;
    } t_out_item;

    typedef struct packed {
        logic [2:0]             token_kind;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   start_line;
        logic [LINE_BITS-1:0]   start_column;
    } t_token;

    // tokens caused by one byte, slot 0 first; count is 1..3
    typedef struct packed {
        logic [1:0]             count;
        t_token [SLOTS-1:0]     slot;
    } t_bundle;

    function automatic t_token mk_tok(
        input logic [2:0]             kind,
        input logic [OFFSET_BITS-1:0] off,
        input logic [OFFSET_BITS-1:0] len,
        input logic [LINE_BITS-1:0]   ln,
        input logic [LINE_BITS-1:0]   col
    );
        t_token t;
        t.token_kind   = kind;
        t.start_offset = off;
        t.token_length = len;
        t.start_line   = ln;
        t.start_column = col;
        return t;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NL);
    endfunction

    function automatic logic is_stop(input logic [7:0] b);
        return is_space(b) || (b == CH_HASH) || (b == CH_QUOTE) ||
               (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_COMMA);
    endfunction

endpackage

// ===== sv/stt_front.sv =====
`timescale 1ns / 1ps

module stt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  stt_pkg::t_in_item i_item,
    output logic              o_ready,
    input  logic              i_full,
    output logic              o_push,
    output stt_pkg::t_bundle  o_bundle
);

    logic [1:0]                      r_mode, n_mode;
    logic [stt_pkg::OFFSET_BITS-1:0] r_pos, n_pos;
    logic [stt_pkg::LINE_BITS-1:0]   r_line, n_line;
    logic [stt_pkg::LINE_BITS-1:0]   r_col, n_col;
    logic [stt_pkg::OFFSET_BITS-1:0] r_tb, n_tb;
    logic [stt_pkg::LINE_BITS-1:0]   r_tl, n_tl;
    logic [stt_pkg::LINE_BITS-1:0]   r_tc, n_tc;

    logic             accept;
    logic [7:0]       b;
    logic             fresh;
    logic [1:0]       cnt;
    stt_pkg::t_bundle bundle;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign b       = i_item.text_byte;

    always_comb begin
        n_mode = r_mode;
        n_tb   = r_tb;
        n_tl   = r_tl;
        n_tc   = r_tc;
        n_pos  = r_pos + stt_pkg::OFFSET_BITS'(1);
        fresh  = 1'b0;
        cnt    = 2'd0;
        bundle = '0;

        if (b == stt_pkg::CH_NL) begin
            n_line = r_line + stt_pkg::LINE_BITS'(1);
            n_col  = '0;
        end else begin
            n_line = r_line;
            n_col  = r_col + stt_pkg::LINE_BITS'(1);
        end

        unique case (r_mode)
            stt_pkg::MODE_LITERAL: begin
                if (stt_pkg::is_stop(b)) begin
                    bundle.slot[cnt] = stt_pkg::mk_tok(stt_pkg::KIND_LITERAL, r_tb,
                                                       r_pos - r_tb, r_tl, r_tc);
                    cnt    = cnt + 2'd1;
                    n_mode = stt_pkg::MODE_IDLE;
                    fresh  = 1'b1;
                end
            end
            stt_pkg::MODE_COMMENT: begin
                if (b == stt_pkg::CH_NL) begin
                    n_mode = stt_pkg::MODE_IDLE;
                end
            end
            stt_pkg::MODE_STRING: begin
                if (b == stt_pkg::CH_QUOTE) begin
                    bundle.slot[cnt] = stt_pkg::mk_tok(stt_pkg::KIND_STRING,
                        r_tb + stt_pkg::OFFSET_BITS'(1),
                        r_pos - r_tb - stt_pkg::OFFSET_BITS'(1), r_tl, r_tc);
                    cnt    = cnt + 2'd1;
                    n_mode = stt_pkg::MODE_IDLE;
                end
            end
            stt_pkg::MODE_IDLE: begin
                fresh = 1'b1;
            end
        endcase

        if (fresh && !stt_pkg::is_space(b)) begin
            priority if (b == stt_pkg::CH_HASH) begin
                n_mode = stt_pkg::MODE_COMMENT;
            end else if (b == stt_pkg::CH_QUOTE) begin
                n_tb   = r_pos;
                n_tl   = n_line;
                n_tc   = n_col;
                n_mode = stt_pkg::MODE_STRING;
            end else if (b == stt_pkg::CH_LBRACK) begin
                bundle.slot[cnt] = stt_pkg::mk_tok(stt_pkg::KIND_LBEGIN, r_pos,
                    stt_pkg::OFFSET_BITS'(1), n_line, n_col);
                cnt = cnt + 2'd1;
            end else if (b == stt_pkg::CH_RBRACK) begin
                bundle.slot[cnt] = stt_pkg::mk_tok(stt_pkg::KIND_LEND, r_pos,
                    stt_pkg::OFFSET_BITS'(1), n_line, n_col);
                cnt = cnt + 2'd1;
            end else begin
                n_tb   = r_pos;
                n_tl   = n_line;
                n_tc   = n_col;
                n_mode = stt_pkg::MODE_LITERAL;
            end
        end

        if (i_item.final_byte) begin
            if (n_mode == stt_pkg::MODE_LITERAL) begin
                bundle.slot[cnt] = stt_pkg::mk_tok(stt_pkg::KIND_LITERAL, n_tb,
                                                   n_pos - n_tb, n_tl, n_tc);
                cnt = cnt + 2'd1;
            end else if (n_mode == stt_pkg::MODE_STRING) begin
                bundle.slot[cnt] = stt_pkg::mk_tok(stt_pkg::KIND_UNTERM,
                    n_tb + stt_pkg::OFFSET_BITS'(1), r_pos - n_tb, n_tl, n_tc);
                cnt = cnt + 2'd1;
            end
            bundle.slot[cnt] = stt_pkg::mk_tok(stt_pkg::KIND_EOT, n_pos, '0,
                                               n_line, n_col);
            cnt    = cnt + 2'd1;
            n_mode = stt_pkg::MODE_IDLE;
            n_pos  = '0;
            n_line = stt_pkg::LINE_BITS'(1);
            n_col  = '0;
            n_tb   = '0;
            n_tl   = '0;
            n_tc   = '0;
        end
        bundle.count = cnt;
    end

    assign o_push   = accept && (cnt != 2'd0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stt_pkg::MODE_IDLE;
            r_pos  <= '0;
            r_line <= stt_pkg::LINE_BITS'(1);
            r_col  <= '0;
            r_tb   <= '0;
            r_tl   <= '0;
            r_tc   <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_line <= n_line;
            r_col  <= n_col;
            r_tb   <= n_tb;
            r_tl   <= n_tl;
            r_tc   <= n_tc;
        end
    end

endmodule

// ===== sv/stt_fifo.sv =====
`timescale 1ns / 1ps

module stt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stt_pkg::t_bundle i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output stt_pkg::t_bundle o_data
);

    stt_pkg::t_bundle r_mem [stt_pkg::FIFO_DEPTH];

    logic [stt_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [stt_pkg::FIFO_AW:0]   r_count, n_count;
    logic                        do_push, do_pop;

    assign o_full  = (r_count == (stt_pkg::FIFO_AW+1)'(stt_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (stt_pkg::FIFO_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (stt_pkg::FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + stt_pkg::FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + stt_pkg::FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/stt_back.sv =====
`timescale 1ns / 1ps

module stt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  stt_pkg::t_bundle   i_data,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output stt_pkg::t_out_item o_item
);

    stt_pkg::t_bundle r_bundle;
    logic [1:0]       r_idx;
    logic             r_have;
    logic             last;
    logic             done;
    stt_pkg::t_token  cur;

    assign last    = (r_idx == (r_bundle.count - 2'd1));
    assign done    = !r_have || (i_ready && last);
    assign o_pop   = done && !i_empty;
    assign o_valid = r_have;
    assign cur     = r_bundle.slot[r_idx];

    assign o_item.token_kind   = cur.token_kind;
    assign o_item.start_offset = cur.start_offset;
    assign o_item.token_length = cur.token_length;
    assign o_item.start_line   = cur.start_line;
    assign o_item.start_column = cur.start_column;
    assign o_item.run_end      = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bundle <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (done) begin
            r_have <= !i_empty;
            r_idx  <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ===== sv/scene_text_tokenizer.sv =====
`timescale 1ns / 1ps

// Scene text tokenizer.
// Input channel (i_valid / o_ready / i_item): one text byte per transaction,
// final_byte set on the last byte of a text. Output channel (o_valid /
// i_ready / o_item): one token per transaction; run_end marks the last token
// caused by a given byte. Each byte gives zero to three tokens.
// A byte is classified and its tokens are bundled in the same cycle; bundles
// wait in a 4-entry queue, and the back end plays them out one token per
// cycle from a held output register, while i_ready is high. A byte's bundle
// is written to a queue entry, then to the output register. Bytes are taken
// one per cycle while the queue has room; the output side sets the rate.
// When the receiver stalls, the current token holds and the queue fills;
// o_ready drops only when all four queue entries are occupied.
// Reset (synchronous, active low) empties the queue, drops o_valid and
// returns the scanner to between-tokens, offset 0, line 1, column 0.
// A final byte also returns the scanner to that state after its end token.

module scene_text_tokenizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  stt_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output stt_pkg::t_out_item  o_item
);

    logic             q_full, q_empty, q_push, q_pop;
    stt_pkg::t_bundle q_wdata, q_rdata;

    stt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .o_ready  (o_ready),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_bundle (q_wdata)
    );

    stt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_data  (q_rdata),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("token valid after reset");

    a_eot_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.token_kind == stt_pkg::KIND_EOT)) |-> o_item.run_end)
        else $error("end token not last of its run");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.token_kind == stt_pkg::KIND_LITERAL ||
                     o_item.token_kind == stt_pkg::KIND_STRING ||
                     o_item.token_kind == stt_pkg::KIND_LBEGIN ||
                     o_item.token_kind == stt_pkg::KIND_LEND ||
                     o_item.token_kind == stt_pkg::KIND_EOT ||
                     o_item.token_kind == stt_pkg::KIND_UNTERM))
        else $error("bad token kind");

    a_bracket_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.token_kind == stt_pkg::KIND_LBEGIN ||
                     o_item.token_kind == stt_pkg::KIND_LEND))
        |-> (o_item.token_length == stt_pkg::OFFSET_BITS'(1)))
        else $error("bracket token length not one");

endmodule

// ===== tb/sv/stt_token_checker.sv =====
`timescale 1ns / 1ps

module stt_token_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_valid,
    input  logic               i_byte_ready,
    input  stt_pkg::t_in_item  i_byte,
    input  logic               i_token_valid,
    input  logic               i_token_ready,
    input  stt_pkg::t_out_item i_token,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    logic [1:0]                      scan_mode   = stt_pkg::MODE_IDLE;
    logic [stt_pkg::OFFSET_BITS-1:0] next_offset = '0;
    logic [stt_pkg::LINE_BITS-1:0]   line_no     = stt_pkg::LINE_BITS'(1);
    logic [stt_pkg::LINE_BITS-1:0]   col_no      = '0;
    logic [stt_pkg::OFFSET_BITS-1:0] tok_offset  = '0;
    logic [stt_pkg::LINE_BITS-1:0]   tok_line    = '0;
    logic [stt_pkg::LINE_BITS-1:0]   tok_col     = '0;

    stt_pkg::t_out_item upcoming_tokens[$];
    int                 fail_count = 0;
    int                 checked    = 0;
    int                 pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == stt_pkg::CH_SPACE) || (b == stt_pkg::CH_TAB) ||
               (b == stt_pkg::CH_CR) || (b == stt_pkg::CH_NL);
    endfunction

    function automatic logic ends_literal(input logic [7:0] b);
        return is_blank(b) || (b == stt_pkg::CH_HASH) || (b == stt_pkg::CH_QUOTE) ||
               (b == stt_pkg::CH_LBRACK) || (b == stt_pkg::CH_RBRACK) ||
               (b == stt_pkg::CH_COMMA);
    endfunction

    function automatic stt_pkg::t_out_item token_of(
        input logic [2:0]                      kind,
        input logic [stt_pkg::OFFSET_BITS-1:0] offset,
        input logic [stt_pkg::OFFSET_BITS-1:0] length,
        input logic [stt_pkg::LINE_BITS-1:0]   line,
        input logic [stt_pkg::LINE_BITS-1:0]   column
    );
        stt_pkg::t_out_item t;
        t.token_kind   = kind;
        t.start_offset = offset;
        t.token_length = length;
        t.start_line   = line;
        t.start_column = column;
        t.run_end      = 1'b0;
        return t;
    endfunction

    task automatic reset_scanner();
        scan_mode   = stt_pkg::MODE_IDLE;
        next_offset = '0;
        line_no     = stt_pkg::LINE_BITS'(1);
        col_no      = '0;
        tok_offset  = '0;
        tok_line    = '0;
        tok_col     = '0;
    endtask

    task automatic open_token(input logic [stt_pkg::OFFSET_BITS-1:0] pos,
                              input logic [1:0] mode);
        tok_offset = pos;
        tok_line   = line_no;
        tok_col    = col_no;
        scan_mode  = mode;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        stt_pkg::t_out_item              made[$];
        logic [stt_pkg::OFFSET_BITS-1:0] pos;
        logic                            fresh;
        pos   = next_offset;
        fresh = 1'b0;
        if (b == stt_pkg::CH_NL) begin
            line_no = line_no + stt_pkg::LINE_BITS'(1);
            col_no  = '0;
        end else begin
            col_no = col_no + stt_pkg::LINE_BITS'(1);
        end
        case (scan_mode)
            stt_pkg::MODE_LITERAL: begin
                if (ends_literal(b)) begin
                    made.push_back(token_of(stt_pkg::KIND_LITERAL, tok_offset,
                                            pos - tok_offset, tok_line, tok_col));
                    scan_mode = stt_pkg::MODE_IDLE;
                    fresh     = 1'b1;
                end
            end
            stt_pkg::MODE_COMMENT: begin
                if (b == stt_pkg::CH_NL) scan_mode = stt_pkg::MODE_IDLE;
            end
            stt_pkg::MODE_STRING: begin
                if (b == stt_pkg::CH_QUOTE) begin
                    made.push_back(token_of(stt_pkg::KIND_STRING,
                                            tok_offset + stt_pkg::OFFSET_BITS'(1),
                                            pos - tok_offset - stt_pkg::OFFSET_BITS'(1),
                                            tok_line, tok_col));
                    scan_mode = stt_pkg::MODE_IDLE;
                end
            end
            default: fresh = 1'b1;
        endcase
        if (fresh && !is_blank(b)) begin
            if (b == stt_pkg::CH_HASH) begin
                scan_mode = stt_pkg::MODE_COMMENT;
            end else if (b == stt_pkg::CH_QUOTE) begin
                open_token(pos, stt_pkg::MODE_STRING);
            end else if (b == stt_pkg::CH_LBRACK) begin
                made.push_back(token_of(stt_pkg::KIND_LBEGIN, pos,
                                        stt_pkg::OFFSET_BITS'(1), line_no, col_no));
            end else if (b == stt_pkg::CH_RBRACK) begin
                made.push_back(token_of(stt_pkg::KIND_LEND, pos,
                                        stt_pkg::OFFSET_BITS'(1), line_no, col_no));
            end else begin
                open_token(pos, stt_pkg::MODE_LITERAL);
            end
        end
        next_offset = pos + stt_pkg::OFFSET_BITS'(1);
        if (last) begin
            if (scan_mode == stt_pkg::MODE_LITERAL) begin
                made.push_back(token_of(stt_pkg::KIND_LITERAL, tok_offset,
                                        next_offset - tok_offset, tok_line, tok_col));
            end else if (scan_mode == stt_pkg::MODE_STRING) begin
                made.push_back(token_of(stt_pkg::KIND_UNTERM,
                                        tok_offset + stt_pkg::OFFSET_BITS'(1),
                                        pos - tok_offset, tok_line, tok_col));
            end
            made.push_back(token_of(stt_pkg::KIND_EOT, next_offset,
                                    stt_pkg::OFFSET_BITS'(0), line_no, col_no));
            reset_scanner();
        end
        if (made.size() > 0) made[made.size() - 1].run_end = 1'b1;
        foreach (made[i]) upcoming_tokens.push_back(made[i]);
    endtask

    function automatic bit field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: token %0d %s expected %0d actual %0d",
                     $time, checked, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_token(input stt_pkg::t_out_item got);
        stt_pkg::t_out_item want;
        bit                 bad;
        if (upcoming_tokens.size() == 0) begin
            $display("%0t: token %0d not expected, actual kind %0d offset %0d length %0d",
                     $time, checked, got.token_kind, got.start_offset, got.token_length);
            fail_count++;
            return;
        end
        want = upcoming_tokens.pop_front();
        bad  = 1'b0;
        bad |= field_bad("token_kind", 32'(want.token_kind), 32'(got.token_kind));
        bad |= field_bad("start_offset", 32'(want.start_offset), 32'(got.start_offset));
        bad |= field_bad("token_length", 32'(want.token_length), 32'(got.token_length));
        bad |= field_bad("start_line", 32'(want.start_line), 32'(got.start_line));
        bad |= field_bad("start_column", 32'(want.start_column), 32'(got.start_column));
        bad |= field_bad("run_end", 32'(want.run_end), 32'(got.run_end));
        if (bad) fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_scanner();
            upcoming_tokens.delete();
        end else begin
            if (i_byte_valid && i_byte_ready)
                scan_byte(i_byte.text_byte, i_byte.final_byte);
            if (i_token_valid && i_token_ready) begin
                check_token(i_token);
                checked++;
            end
        end
        pending = upcoming_tokens.size();
    end

endmodule

// ===== tb/sv/scene_text_tokenizer_test.sv =====
`timescale 1ns / 1ps

module scene_text_tokenizer_test;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               byte_valid  = 1'b0;
    logic               byte_ready;
    stt_pkg::t_in_item  text_in     = '0;
    logic               token_valid;
    logic               token_ready = 1'b0;
    stt_pkg::t_out_item token_out;

    int fail_count;
    int pending;
    int checked;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asked   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int bytes_sent   = 0;
    int texts_sent   = 0;
    int quiet_cycles = 0;

    logic [7:0] text_q[$];

    always #5 clk = ~clk;

    scene_text_tokenizer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (byte_valid),
        .o_ready (byte_ready),
        .i_item  (text_in),
        .o_valid (token_valid),
        .i_ready (token_ready),
        .o_item  (token_out)
    );

    stt_token_checker token_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_byte_valid  (byte_valid),
        .i_byte_ready  (byte_ready),
        .i_byte        (text_in),
        .i_token_valid (token_valid),
        .i_token_ready (token_ready),
        .i_token       (token_out),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            token_ready = 1'b0;
        end else begin
            token_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((byte_valid && byte_ready) || (token_valid && token_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] literal_char();
        case ($urandom_range(0, 7))
            0:       return 8'($urandom_range(8'h00, 8'h08));
            1:       return 8'($urandom_range(8'h0E, 8'h1F));
            2:       return 8'($urandom_range(8'h24, 8'h2B));
            3:       return 8'($urandom_range(8'h80, 8'hFF));
            4:       return 8'($urandom_range(8'h5E, 8'h7F));
            default: return 8'($urandom_range(8'h2D, 8'h5A));
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == stt_pkg::CH_QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] comment_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == stt_pkg::CH_NL);
        return b;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return stt_pkg::CH_SPACE;
            1:       return stt_pkg::CH_TAB;
            2:       return stt_pkg::CH_CR;
            default: return stt_pkg::CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0:       return stt_pkg::CH_QUOTE;
            1:       return stt_pkg::CH_HASH;
            2:       return stt_pkg::CH_LBRACK;
            3:       return stt_pkg::CH_RBRACK;
            4:       return stt_pkg::CH_COMMA;
            5:       return stt_pkg::CH_NL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_chars(input string s);
        foreach (s[i]) text_q.push_back(s[i]);
    endtask

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid         = 1'b1;
        text_in.text_byte  = b;
        text_in.final_byte = last;
        do @(posedge clk); while (!byte_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        texts_sent++;
    endtask

    task automatic drain();
        byte_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic make_text();
        int pieces;
        int n;
        pieces = $urandom_range(1, 6);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 6);
                    repeat (n) text_q.push_back(literal_char());
                end
                3, 4: begin
                    text_q.push_back(stt_pkg::CH_QUOTE);
                    n = $urandom_range(0, 5);
                    repeat (n) text_q.push_back(text_char());
                    text_q.push_back(stt_pkg::CH_QUOTE);
                end
                5: text_q.push_back(stt_pkg::CH_LBRACK);
                6: text_q.push_back(stt_pkg::CH_RBRACK);
                7: begin
                    text_q.push_back(stt_pkg::CH_COMMA);
                    n = $urandom_range(0, 3);
                    repeat (n) text_q.push_back(literal_char());
                end
                8: begin
                    text_q.push_back(stt_pkg::CH_HASH);
                    n = $urandom_range(0, 5);
                    repeat (n) text_q.push_back(comment_char());
                    text_q.push_back(stt_pkg::CH_NL);
                end
                default: begin
                    n = $urandom_range(1, 8);
                    repeat (n) text_q.push_back(noise_byte());
                end
            endcase
            n = $urandom_range(0, 2);
            repeat (n) text_q.push_back(blank_char());
        end
        // some texts are cut off inside a string or a comment
        case ($urandom_range(0, 7))
            0: begin
                text_q.push_back(stt_pkg::CH_QUOTE);
                n = $urandom_range(0, 3);
                repeat (n) text_q.push_back(text_char());
            end
            1: begin
                text_q.push_back(stt_pkg::CH_HASH);
                n = $urandom_range(0, 3);
                repeat (n) text_q.push_back(comment_char());
            end
            default: ;
        endcase
    endtask

    task automatic random_texts(input int n_bytes);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            make_text();
            send_text();
        end
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 34;
        rx_idle_pct = 59;
        add_chars("[");
        text_q.push_back(8'h00);
        add_chars(",");
        text_q.push_back(8'hFF);
        add_chars("]\"x\"#z\n\t\015 k\"q");
        send_text();
        add_chars("a[");
        send_text();
        add_chars("#");
        send_text();
        add_chars("\"");
        send_text();
        add_chars(",");
        send_text();
        add_chars("\n");
        send_text();

        random_texts(60);
        hold_asked++;
        random_texts(60);
        drain();

        tx_idle_pct = 59;
        rx_idle_pct = 34;
        random_texts(125);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_asked++;
        random_texts(125);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d text bytes in %0d texts and checked %0d tokens.",
                 bytes_sent, texts_sent, checked);
        $display("Covered strings, literals, brackets, comments and cut-off texts under stalls.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== scene_text_tokenizer.f =====
sv/stt_pkg.sv
sv/stt_front.sv
sv/stt_fifo.sv
sv/stt_back.sv
sv/scene_text_tokenizer.sv
tb/sv/stt_token_checker.sv
tb/sv/scene_text_tokenizer_test.sv
